[src/ehp_pkg.sv]
`default_nettype none
package ehp_pkg;

  localparam int unsigned MaxFrameBytes = 65536;

  localparam logic [15:0] TpidA  = 16'h8100;
  localparam logic [15:0] TpidB  = 16'h88A8;
  localparam logic [15:0] EtArp  = 16'h0806;
  localparam logic [15:0] EtIpv4 = 16'h0800;
  localparam logic [15:0] EtIpv6 = 16'h86DD;

  localparam int unsigned EthHdr = 14;
  localparam int unsigned TagLen = 4;
  localparam int unsigned SzArp  = 28;
  localparam int unsigned SzIpv4 = 20;
  localparam int unsigned SzIpv6 = 40;
  localparam int unsigned SzIcmp = 8;
  localparam int unsigned SzTcp  = 20;
  localparam int unsigned SzUdp  = 8;

  localparam int unsigned NumFields = 17;
  localparam logic [4:0]  LastField = 5'd16;

  localparam logic [7:0] ProtoIcmp4 = 8'd1;
  localparam logic [7:0] ProtoTcp   = 8'd6;
  localparam logic [7:0] ProtoUdp   = 8'd17;
  localparam logic [7:0] ProtoIcmp6 = 8'd58;

  localparam logic [7:0] NdpRs = 8'd133;
  localparam logic [7:0] NdpRa = 8'd134;
  localparam logic [7:0] NdpNs = 8'd135;
  localparam logic [7:0] NdpNa = 8'd136;

  localparam logic [15:0] ArpOpReq = 16'd1;
  localparam logic [15:0] ArpOpRep = 16'd2;

  function automatic logic is_tpid(input logic [15:0] t);
    return (t == TpidA) || (t == TpidB);
  endfunction

  function automatic logic [5:0] ihl_bytes(input logic [7:0] b0);
    logic [3:0] ihl;
    ihl = b0[3:0];
    if (ihl < 4'd5) ihl = 4'd5;
    return {ihl, 2'b00};
  endfunction

endpackage
`default_nettype wire

[src/ethernet_l2_l4_header_parser_unit.sv]
// Ethernet/VLAN/ARP/IPv4/IPv6/ICMP/TCP/UDP header parser.
// Input channel: one frame byte per word (data_byte_i, last_byte_i), valid/stall.
// A valid byte is taken in every cycle that in_stall_o is low; parsing finishes in that cycle.
// Accepting the last byte of a frame moves the parsed header state into a
// frame snapshot and clears the live state, so the next frame can start at once.
// Output channel: 17 metadata words per frame (field_id_o 0..16, field_value_o),
// last_word_o marks field 16. The accepted last byte sets the busy flag; the words
// are then loaded into the output register and leave it one word per cycle while the
// receiver does not stall.
// Throughput: one byte per cycle; the 17-word drain of one frame overlaps the
// bytes of the next. A last byte is held off (in_stall_o) only while the
// snapshot of the previous frame is still being drained, so frames of at least
// 18 bytes stream at one byte per cycle while the receiver does not stall.
// An out_stall_i holds the output word and the drain counter; input bytes keep
// flowing until a last byte meets a busy snapshot.
// Reset clears the live parse state, the drain counter and output valid.
`default_nettype none
module ethernet_l2_l4_header_parser_unit #(
  parameter int unsigned MAX_FRAME_BYTES = ehp_pkg::MaxFrameBytes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [4:0]       field_id_o,
  output logic [63:0]      field_value_o,
  output logic             last_word_o
);

  localparam int unsigned PW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned EW = $clog2(MAX_FRAME_BYTES + 5);

  logic [PW-1:0]       pos_q, pos_d;
  logic [EW-1:0]       end_q, end_d;
  logic [15:0]         et_q, et_d, tag_q, tag_d;
  logic [0:5][7:0]     dmac_q, dmac_d, smac_q, smac_d;
  logic [0:47][7:0]    l3_q, l3_d;
  logic [0:15][7:0]    l4_q, l4_d;

  logic [PW-1:0]       s_pos_q;
  logic [EW-1:0]       s_end_q;
  logic [15:0]         s_et_q, s_tag_q;
  logic [0:5][7:0]     s_dmac_q, s_smac_q;
  logic [0:47][7:0]    s_l3_q;
  logic [0:15][7:0]    s_l4_q;

  logic                busy_q;
  logic [4:0]          cnt_q;
  logic                out_valid_q, out_last_q;
  logic [4:0]          out_id_q;
  logic [63:0]         out_val_q;

  logic                in_acc, adv;
  logic [EW:0]         pos_x, end_x, l4s_x, off_x, off4_x;

  assign in_stall_o = busy_q & last_byte_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign adv        = ~out_valid_q | ~out_stall_i;

  assign pos_x = (EW+1)'(pos_q);
  assign end_x = (EW+1)'(end_q);
  assign off_x = pos_x - end_x;
  assign l4s_x = end_x + ((et_q == ehp_pkg::EtIpv6) ? (EW+1)'(ehp_pkg::SzIpv6)
                                                    : (EW+1)'(ehp_pkg::ihl_bytes(l3_q[0])));
  assign off4_x = pos_x - l4s_x;

  always_comb begin
    pos_d  = pos_q;
    end_d  = end_q;
    et_d   = et_q;
    tag_d  = tag_q;
    dmac_d = dmac_q;
    smac_d = smac_q;
    l3_d   = l3_q;
    l4_d   = l4_q;
    if (pos_q < PW'(MAX_FRAME_BYTES)) begin
      pos_d = pos_q + PW'(1);
      for (int k = 0; k < 6; k++) begin
        if (pos_x == (EW+1)'(k)) dmac_d[k] = data_byte_i;
        if (pos_x == (EW+1)'(k + 6)) smac_d[k] = data_byte_i;
      end
      if (pos_x + (EW+1)'(2) == end_x) begin
        et_d = {et_q[7:0], data_byte_i};
      end else if (pos_x + (EW+1)'(1) == end_x) begin
        et_d = {et_q[7:0], data_byte_i};
        if (ehp_pkg::is_tpid(et_d)) begin
          tag_d = et_d;
          end_d = end_q + EW'(ehp_pkg::TagLen);
        end
      end else if (pos_x >= end_x) begin
        for (int k = 0; k < 48; k++) begin
          if (off_x == (EW+1)'(k)) l3_d[k] = l3_q[k] | data_byte_i;
        end
        if ((et_q == ehp_pkg::EtIpv4 || et_q == ehp_pkg::EtIpv6) && pos_x >= l4s_x) begin
          for (int k = 0; k < 16; k++) begin
            if (off4_x == (EW+1)'(k)) l4_d[k] = l4_q[k] | data_byte_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      end_q  <= EW'(ehp_pkg::EthHdr);
      et_q   <= '0;
      tag_q  <= '0;
      dmac_q <= '0;
      smac_q <= '0;
      l3_q   <= '0;
      l4_q   <= '0;
    end else if (in_acc) begin
      if (last_byte_i) begin
        pos_q  <= '0;
        end_q  <= EW'(ehp_pkg::EthHdr);
        et_q   <= '0;
        tag_q  <= '0;
        dmac_q <= '0;
        smac_q <= '0;
        l3_q   <= '0;
        l4_q   <= '0;
      end else begin
        pos_q  <= pos_d;
        end_q  <= end_d;
        et_q   <= et_d;
        tag_q  <= tag_d;
        dmac_q <= dmac_d;
        smac_q <= smac_d;
        l3_q   <= l3_d;
        l4_q   <= l4_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && last_byte_i) begin
      s_pos_q  <= pos_d;
      s_end_q  <= end_d;
      s_et_q   <= et_d;
      s_tag_q  <= tag_d;
      s_dmac_q <= dmac_d;
      s_smac_q <= smac_d;
      s_l3_q   <= l3_d;
      s_l4_q   <= l4_d;
    end
  end

  logic [EW:0]       len_x, send_x;
  logic [15:0]       et;
  logic              l2ok;
  logic [7:0]        proto;
  logic [15:0]       l3pay, tl;
  logic [5:0]        ihlb, doff;
  logic [14:0]       flags;
  logic [16:0][63:0] vv;

  assign len_x  = (EW+1)'(s_pos_q);
  assign send_x = (EW+1)'(s_end_q);
  assign ihlb   = ehp_pkg::ihl_bytes(s_l3_q[0]);
  assign tl     = {s_l3_q[2], s_l3_q[3]};
  assign doff   = {s_l4_q[12][7:4], 2'b00};

  always_comb begin
    vv    = '0;
    flags = 15'd1;
    proto = '0;
    l3pay = '0;
    if (send_x > (EW+1)'(ehp_pkg::EthHdr) && len_x < send_x + (EW+1)'(2)) begin
      et   = s_tag_q;
      l2ok = 1'b0;
    end else begin
      if (len_x >= send_x) et = s_et_q;
      else if (len_x + (EW+1)'(1) == send_x) et = {s_et_q[7:0], 8'h00};
      else et = '0;
      l2ok = ~ehp_pkg::is_tpid(et);
    end
    if (l2ok && et == ehp_pkg::EtArp && len_x >= send_x + (EW+1)'(ehp_pkg::SzArp)) begin
      if ({s_l3_q[6], s_l3_q[7]} == ehp_pkg::ArpOpReq) flags[3] = 1'b1;
      else if ({s_l3_q[6], s_l3_q[7]} == ehp_pkg::ArpOpRep) flags[4] = 1'b1;
      vv[8]  = 64'({s_l3_q[14], s_l3_q[15], s_l3_q[16], s_l3_q[17]});
      vv[10] = 64'({s_l3_q[24], s_l3_q[25], s_l3_q[26], s_l3_q[27]});
    end else if (l2ok && et == ehp_pkg::EtIpv4 &&
                 len_x >= send_x + (EW+1)'(ehp_pkg::SzIpv4)) begin
      flags[5] = 1'b1;
      flags[1] = 1'b1;
      vv[8]  = 64'({s_l3_q[12], s_l3_q[13], s_l3_q[14], s_l3_q[15]});
      vv[10] = 64'({s_l3_q[16], s_l3_q[17], s_l3_q[18], s_l3_q[19]});
      proto  = s_l3_q[9];
      l3pay  = (tl > 16'(ihlb)) ? tl - 16'(ihlb) : 16'd0;
      vv[5]  = 64'(tl);
    end else if (l2ok && et == ehp_pkg::EtIpv6 &&
                 len_x >= send_x + (EW+1)'(ehp_pkg::SzIpv6)) begin
      flags[6] = 1'b1;
      flags[1] = 1'b1;
      vv[7]  = s_l3_q[8:15];
      vv[8]  = s_l3_q[16:23];
      vv[9]  = s_l3_q[24:31];
      vv[10] = s_l3_q[32:39];
      proto  = s_l3_q[6];
      l3pay  = {s_l3_q[4], s_l3_q[5]};
      vv[5]  = 64'(l3pay);
    end
    vv[4] = 64'(proto);
    vv[6] = 64'(l3pay);
    unique case (proto)
      ehp_pkg::ProtoIcmp4: begin
        if (l3pay >= 16'(ehp_pkg::SzIcmp)) flags[7] = 1'b1;
      end
      ehp_pkg::ProtoIcmp6: begin
        if (l3pay >= 16'(ehp_pkg::SzIcmp)) begin
          flags[8] = 1'b1;
          if (s_l4_q[0] == ehp_pkg::NdpRs || s_l4_q[0] == ehp_pkg::NdpNs) flags[9] = 1'b1;
          else if (s_l4_q[0] == ehp_pkg::NdpRa || s_l4_q[0] == ehp_pkg::NdpNa)
            flags[10] = 1'b1;
        end
      end
      ehp_pkg::ProtoTcp: begin
        if (l3pay >= 16'(ehp_pkg::SzTcp)) begin
          if (et == ehp_pkg::EtIpv4) flags[11] = 1'b1;
          else flags[12] = 1'b1;
          flags[2] = 1'b1;
          vv[11] = 64'({s_l4_q[0], s_l4_q[1]});
          vv[12] = 64'({s_l4_q[2], s_l4_q[3]});
          vv[13] = 64'({s_l4_q[4], s_l4_q[5], s_l4_q[6], s_l4_q[7]});
          vv[14] = 64'({s_l4_q[8], s_l4_q[9], s_l4_q[10], s_l4_q[11]});
          vv[15] = (l3pay > 16'(doff)) ? 64'(l3pay - 16'(doff)) : 64'd0;
          vv[16] = 64'(l3pay);
        end
      end
      ehp_pkg::ProtoUdp: begin
        if (l3pay >= 16'(ehp_pkg::SzUdp)) begin
          if (et == ehp_pkg::EtIpv4) flags[13] = 1'b1;
          else flags[14] = 1'b1;
          flags[2] = 1'b1;
          vv[11] = 64'({s_l4_q[0], s_l4_q[1]});
          vv[12] = 64'({s_l4_q[2], s_l4_q[3]});
          vv[15] = 64'(l3pay - 16'(ehp_pkg::SzUdp));
          vv[16] = 64'({s_l4_q[4], s_l4_q[5]});
        end
      end
      default: ;
    endcase
    vv[0] = 64'(flags);
    vv[1] = 64'(et);
    vv[2] = 64'(s_dmac_q);
    vv[3] = 64'(s_smac_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= busy_q;
        if (busy_q) begin
          if (cnt_q == ehp_pkg::LastField) begin
            cnt_q  <= '0;
            busy_q <= 1'b0;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
      end
      if (in_acc && last_byte_i) busy_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && busy_q) begin
      out_id_q   <= cnt_q;
      out_val_q  <= vv[cnt_q];
      out_last_q <= (cnt_q == ehp_pkg::LastField);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign field_id_o    = out_id_q;
  assign field_value_o = out_val_q;
  assign last_word_o   = out_last_q;

`ifndef SYNTHESIS
  a_no_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && busy_q) |-> !last_byte_i) else $error("last byte taken while draining");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ehp_pkg::LastField) else $error("drain counter out of range");
  a_last_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_id_q == ehp_pkg::LastField))
    else $error("last word on wrong field");
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> (cnt_q == 5'd0)) else $error("drain did not start at field 0");
`endif

endmodule
`default_nettype wire

[tb/tb_ethernet_l2_l4_header_parser_unit.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_ethernet_l2_l4_header_parser_unit;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned RandomBytes = 60;

  typedef enum logic [1:0] {L3_RAW, L3_ARP, L3_V4, L3_V6} l3_kind_e;

  typedef struct {
    l3_kind_e   l3;
    logic [7:0] proto;
    int         tags;
    int         len;
    bit         clean;
    int         flags;
  } frame_row_t;

  typedef struct {
    logic [4:0]  id;
    logic [63:0] value;
    logic        last;
  } meta_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [4:0]  field_id_o;
  logic [63:0] field_value_o;
  logic        last_word_o;

  ethernet_l2_l4_header_parser_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i, .last_byte_i,
    .out_valid_o, .out_stall_i, .field_id_o, .field_value_o, .last_word_o
  );

  meta_word_t  meta_q[$];
  logic [7:0]  frame_q[$];
  int          fail_cnt;
  int unsigned cycle_cnt;
  int          rand_bytes;
  bit          in_random;
  bit          quiet;
  bit          hold_off;

  // live parse state of the predictor
  int          pos;
  int          l2_end;
  logic [15:0] eth_type;
  logic [15:0] tag_seen;
  logic [63:0] dmac, smac;
  logic [7:0]  l3_hdr[48];
  logic [7:0]  l4_hdr[16];
  logic [14:0] frame_flags;

  frame_row_t rows[8] = '{
    '{L3_RAW, 8'd0, 0, 1, 1, 1},
    '{L3_RAW, 8'd0, 0, 13, 1, 1},
    '{L3_ARP, 8'd1, 0, 0, 1, 'h9},
    '{L3_V4, ehp_pkg::ProtoTcp, 0, 0, 1, 'h827},
    '{L3_V4, ehp_pkg::ProtoUdp, 1, 0, 1, 'h2027},
    '{L3_V6, ehp_pkg::ProtoTcp, 0, 0, 1, 'h1047},
    '{L3_V6, ehp_pkg::ProtoIcmp6, 0, 0, 1, 'h343},
    '{L3_V4, ehp_pkg::ProtoUdp, 1, 16, 1, 1}
  };

  function automatic bit tag_type(logic [15:0] t);
    return t == ehp_pkg::TpidA || t == ehp_pkg::TpidB;
  endfunction

  function automatic int hdr_len_v4();
    int h;
    h = l3_hdr[0][3:0];
    if (h < 5) h = 5;
    return h * 4;
  endfunction

  function automatic logic [63:0] l3_bytes(int off, int cnt);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < cnt; i++) r = {r[55:0], l3_hdr[off + i]};
    return r;
  endfunction

  function automatic logic [63:0] l4_bytes(int off, int cnt);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < cnt; i++) r = {r[55:0], l4_hdr[off + i]};
    return r;
  endfunction

  function automatic int sat_diff(int a, int b);
    return a > b ? a - b : 0;
  endfunction

  function automatic void clear_parse();
    pos = 0;
    l2_end = ehp_pkg::EthHdr;
    eth_type = '0;
    tag_seen = '0;
    dmac = '0;
    smac = '0;
    foreach (l3_hdr[i]) l3_hdr[i] = '0;
    foreach (l4_hdr[i]) l4_hdr[i] = '0;
  endfunction

  function automatic void absorb_byte(int p, logic [7:0] b);
    int s;
    if (p < 6) dmac |= 64'(b) << (40 - 8 * p);
    else if (p < 12) smac |= 64'(b) << (40 - 8 * (p - 6));
    if (p + 2 == l2_end) begin
      eth_type = {eth_type[7:0], b};
    end else if (p + 1 == l2_end) begin
      eth_type = {eth_type[7:0], b};
      if (tag_type(eth_type)) begin
        tag_seen = eth_type;
        l2_end += ehp_pkg::TagLen;
      end
    end else if (p >= l2_end) begin
      if (p - l2_end < 48) l3_hdr[p - l2_end] = b;
      if (eth_type == ehp_pkg::EtIpv4 || eth_type == ehp_pkg::EtIpv6) begin
        s = l2_end + (eth_type == ehp_pkg::EtIpv6 ? ehp_pkg::SzIpv6 : hdr_len_v4());
        if (p >= s && p - s < 16) l4_hdr[p - s] = b;
      end
    end
  endfunction

  function automatic void close_frame();
    logic [63:0] v[17];
    logic [15:0] et;
    logic [7:0]  proto;
    logic [7:0]  icmp_type;
    int          len, l2pay, l3pay, tl;
    bit          l2ok;
    len = pos;
    l3pay = 0;
    proto = '0;
    foreach (v[i]) v[i] = '0;
    frame_flags = 15'h1;
    if (l2_end > ehp_pkg::EthHdr && len < l2_end + 2) begin
      et = tag_seen;
      l2ok = 0;
    end else begin
      if (len >= l2_end) et = eth_type;
      else if (len + 1 == l2_end) et = {eth_type[7:0], 8'h00};
      else et = '0;
      l2ok = !tag_type(et);
    end
    l2pay = sat_diff(len, l2_end);
    if (l2ok && et == ehp_pkg::EtArp && l2pay >= ehp_pkg::SzArp) begin
      if (l3_bytes(6, 2) == 64'(ehp_pkg::ArpOpReq)) frame_flags[3] = 1;
      else if (l3_bytes(6, 2) == 64'(ehp_pkg::ArpOpRep)) frame_flags[4] = 1;
      v[8] = l3_bytes(14, 4);
      v[10] = l3_bytes(24, 4);
    end else if (l2ok && et == ehp_pkg::EtIpv4 && l2pay >= ehp_pkg::SzIpv4) begin
      tl = int'(l3_bytes(2, 2));
      frame_flags[5] = 1;
      frame_flags[1] = 1;
      v[8] = l3_bytes(12, 4);
      v[10] = l3_bytes(16, 4);
      proto = l3_hdr[9];
      l3pay = tl == 0 ? 0 : sat_diff(tl, hdr_len_v4());
      v[5] = 64'(tl);
    end else if (l2ok && et == ehp_pkg::EtIpv6 && l2pay >= ehp_pkg::SzIpv6) begin
      frame_flags[6] = 1;
      frame_flags[1] = 1;
      v[7] = l3_bytes(8, 8);
      v[8] = l3_bytes(16, 8);
      v[9] = l3_bytes(24, 8);
      v[10] = l3_bytes(32, 8);
      proto = l3_hdr[6];
      l3pay = int'(l3_bytes(4, 2));
      v[5] = 64'(l3pay);
    end
    v[4] = 64'(proto);
    v[6] = 64'(l3pay);
    if (proto == ehp_pkg::ProtoIcmp4) begin
      if (l3pay >= ehp_pkg::SzIcmp) frame_flags[7] = 1;
    end else if (proto == ehp_pkg::ProtoIcmp6) begin
      if (l3pay >= ehp_pkg::SzIcmp) begin
        icmp_type = l4_hdr[0];
        frame_flags[8] = 1;
        if (icmp_type == ehp_pkg::NdpRs || icmp_type == ehp_pkg::NdpNs)
          frame_flags[9] = 1;
        else if (icmp_type == ehp_pkg::NdpRa || icmp_type == ehp_pkg::NdpNa)
          frame_flags[10] = 1;
      end
    end else if (proto == ehp_pkg::ProtoTcp) begin
      if (l3pay >= ehp_pkg::SzTcp) begin
        frame_flags[2] = 1;
        if (et == ehp_pkg::EtIpv4) frame_flags[11] = 1;
        else frame_flags[12] = 1;
        v[11] = l4_bytes(0, 2);
        v[12] = l4_bytes(2, 2);
        v[13] = l4_bytes(4, 4);
        v[14] = l4_bytes(8, 4);
        v[15] = 64'(sat_diff(l3pay, l4_hdr[12][7:4] * 4));
        v[16] = 64'(l3pay);
      end
    end else if (proto == ehp_pkg::ProtoUdp) begin
      if (l3pay >= ehp_pkg::SzUdp) begin
        frame_flags[2] = 1;
        if (et == ehp_pkg::EtIpv4) frame_flags[13] = 1;
        else frame_flags[14] = 1;
        v[11] = l4_bytes(0, 2);
        v[12] = l4_bytes(2, 2);
        v[15] = 64'(l3pay - ehp_pkg::SzUdp);
        v[16] = l4_bytes(4, 2);
      end
    end
    v[0] = 64'(frame_flags);
    v[1] = 64'(et);
    v[2] = dmac;
    v[3] = smac;
    for (int k = 0; k < ehp_pkg::NumFields; k++)
      meta_q.push_back('{5'(k), v[k], 5'(k) == ehp_pkg::LastField});
    clear_parse();
  endfunction

  function automatic void push16(logic [15:0] w);
    frame_q.push_back(w[15:8]);
    frame_q.push_back(w[7:0]);
  endfunction

  function automatic void push_rand(int n);
    for (int i = 0; i < n; i++) frame_q.push_back(8'($urandom));
  endfunction

  function automatic void build_frame(frame_row_t r);
    int ihl, l4len, pay, tot;
    logic [7:0] p;
    frame_q.delete();
    push_rand(12);
    for (int i = 0; i < r.tags; i++) begin
      push16($urandom_range(1) ? ehp_pkg::TpidA : ehp_pkg::TpidB);
      push_rand(2);
    end
    p = r.proto;
    pay = r.clean ? 0 : $urandom_range(12);
    l4len = p == ehp_pkg::ProtoTcp ? ehp_pkg::SzTcp :
            (p == ehp_pkg::ProtoUdp || p == ehp_pkg::ProtoIcmp4 || p == ehp_pkg::ProtoIcmp6)
            ? ehp_pkg::SzUdp : $urandom_range(20);
    case (r.l3)
      L3_RAW: push16(r.clean ? 16'h0000 : 16'($urandom));
      L3_ARP: begin
        push16(ehp_pkg::EtArp);
        push_rand(6);
        push16(r.clean ? 16'(p) : 16'($urandom_range(3)));
        push_rand(20);
      end
      L3_V4: begin
        push16(ehp_pkg::EtIpv4);
        ihl = (r.clean || $urandom_range(1)) ? 5 : $urandom_range(15);
        tot = (ihl < 5 ? 20 : ihl * 4) + l4len + pay;
        if (!r.clean && $urandom_range(3) == 0) tot = $urandom_range(65535);
        frame_q.push_back({4'h4, 4'(ihl)});
        push_rand(1);
        push16(16'(tot));
        push_rand(5);
        frame_q.push_back(p);
        push_rand(10);
        if (ihl > 5) push_rand((ihl - 5) * 4);
      end
      default: begin
        push16(ehp_pkg::EtIpv6);
        tot = l4len + pay;
        if (!r.clean && $urandom_range(3) == 0) tot = $urandom_range(65535);
        frame_q.push_back(8'h60);
        push_rand(3);
        push16(16'(tot));
        frame_q.push_back(p);
        push_rand(33);
      end
    endcase
    if (r.l3 == L3_V4 || r.l3 == L3_V6) begin
      if (p == ehp_pkg::ProtoTcp) begin
        push_rand(12);
        frame_q.push_back(r.clean ? 8'h50 : 8'($urandom));
        push_rand(7);
      end else if (p == ehp_pkg::ProtoUdp) begin
        push_rand(4);
        push16(r.clean ? 16'(ehp_pkg::SzUdp + pay) : 16'($urandom));
        push_rand(2);
      end else if (p == ehp_pkg::ProtoIcmp6) begin
        frame_q.push_back(r.clean ? ehp_pkg::NdpNs :
                          ($urandom_range(1) ? 8'(133 + $urandom_range(3)) : 8'($urandom)));
        push_rand(7);
      end else begin
        push_rand(l4len);
      end
    end
    push_rand(pay);
    if (r.len > 0) begin
      while (frame_q.size() > r.len) void'(frame_q.pop_back());
      if (frame_q.size() < r.len) push_rand(r.len - frame_q.size());
    end else if (!r.clean && $urandom_range(3) == 0) begin
      tot = $urandom_range(frame_q.size(), 1);
      while (frame_q.size() > tot) void'(frame_q.pop_back());
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (pos < ehp_pkg::MaxFrameBytes) begin
      absorb_byte(pos, b);
      pos++;
    end
    if (last) close_frame();
    if (in_random) rand_bytes++;
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk_i)
    out_stall_i <= hold_off || (!quiet && $urandom_range(99) < 15);

  initial begin
    hold_off = 1'b0;
    wait (rst_ni === 1'b1);
    repeat (150) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    meta_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (meta_q.size() == 0) begin
        $error("unexpected word: field_id %0d value %h", field_id_o, field_value_o);
        fail_cnt++;
      end else begin
        w = meta_q.pop_front();
        if (field_id_o !== w.id) begin
          $error("field_id: expected %0d, got %0d", w.id, field_id_o);
          fail_cnt++;
        end
        if (field_value_o !== w.value) begin
          $error("field_value (id %0d): expected %h, got %h", w.id, w.value, field_value_o);
          fail_cnt++;
        end
        if (last_word_o !== w.last) begin
          $error("last_word (id %0d): expected %0d, got %0d", w.id, w.last, last_word_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    frame_row_t r;
    int         pick;
    fail_cnt = 0;
    cycle_cnt = 0;
    rand_bytes = 0;
    in_random = 0;
    quiet = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    clear_parse();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (rows[i]) begin
      build_frame(rows[i]);
      send_frame();
      if (rows[i].flags >= 0 && int'(frame_flags) != rows[i].flags) begin
        $error("flags of frame %0d: expected %h, got %h", i, rows[i].flags, frame_flags);
        fail_cnt++;
      end
    end
    in_random = 1;
    while (rand_bytes < RandomBytes) begin
      quiet = rand_bytes < 40;
      pick = $urandom_range(99);
      r.l3 = pick < 10 ? L3_RAW : pick < 25 ? L3_ARP : pick < 65 ? L3_V4 : L3_V6;
      pick = $urandom_range(4);
      r.proto = pick == 0 ? ehp_pkg::ProtoIcmp4 : pick == 1 ? ehp_pkg::ProtoTcp :
                pick == 2 ? ehp_pkg::ProtoUdp : pick == 3 ? ehp_pkg::ProtoIcmp6 :
                8'($urandom);
      r.tags = $urandom_range(3) == 0 ? $urandom_range(3, 1) : 0;
      r.len = $urandom_range(7) == 0 ? $urandom_range(40, 1) : 0;
      r.clean = 0;
      r.flags = -1;
      build_frame(r);
      send_frame();
    end
    quiet = 0;
    in_valid_i <= 1'b0;
    while (meta_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
